// File: design/sbus_frame_decoder_assert.svh
// Assertion macros for the S.BUS frame decoder.
`ifndef SBUS_FRAME_DECODER_ASSERT_SVH
`define SBUS_FRAME_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is high
`define SBUSFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define SBUSFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SBUSFD_ASSERT(label, clk, rst, prop, msg)
`define SBUSFD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: design/sbusfd_pkg.sv
package sbusfd_pkg;

   localparam logic [7:0]  START_BYTE = 8'h0f;
   localparam logic [7:0]  END_MASK   = 8'hc4;
   localparam logic [7:0]  END_MATCH  = 8'h04;
   localparam int          DATA_LEN   = 22;
   localparam logic [4:0]  DATA_FIRST = 5'd1;
   localparam logic [4:0]  DATA_LAST  = 5'd22;
   localparam logic [4:0]  FRAME_END  = 5'd24;
   localparam logic [4:0]  LAST_ADDR  = 5'd21;
   localparam logic [3:0]  LAST_CHAN  = 4'd15;
   localparam logic [3:0]  CHAN_BITS  = 4'd11;
   localparam logic [3:0]  BYTE_BITS  = 4'd8;
   localparam logic [10:0] VAL_OFFSET = 11'd200;
   localparam logic [11:0] PULSE_BASE = 12'd1000;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_COLLECT,
      ST_SKIP,
      ST_READ,
      ST_USE
   } parse_state_type;

   // End byte is 0x00 or matches the end marker pattern
   function automatic logic end_ok(input logic [7:0] b);
      return (b == 8'h00) || ((b & END_MASK) == END_MATCH);
   endfunction

   // round((v - 200) / 1.6) + 1000, saturated at 1000 below 200
   function automatic logic [11:0] map_pulse(input logic [10:0] v);
      logic [10:0] d;
      logic [13:0] p;
      d = v - VAL_OFFSET;
      p = {1'b0, d, 2'b00} + 14'(d) + 14'd4;
      if (v < VAL_OFFSET) begin
         return PULSE_BASE;
      end
      return 12'(p >> 3) + PULSE_BASE;
   endfunction

endpackage

// File: design/sbus_frame_decoder.sv
// S.BUS frame decoder. Takes one received byte per transfer on req_, hunts for
// the 0x0f start byte and stores data bytes 1..22 of the 25-byte frame in a
// 22-byte synchronous memory. While hunting, collecting or skipping, one byte
// is taken per cycle. After a good end byte (0x00, or (b & 0xc4) == 0x04) the
// block stops taking bytes and decodes: it reads the stored bytes one at a
// time, each in two steps (memory read, then merge into a bit accumulator),
// waits whenever rsp_ stalls with a channel ready, and gives sixteen
// transfers of channel index and pulse width in microseconds (1000..2154),
// the last one with rsp_tlast high. The single read port of the frame memory
// is why the bytes are read one at a time. A bad end byte gives no output;
// bytes are then dropped up to and including the next valid end-marker byte.
module sbus_frame_decoder
   import sbusfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] channel, [15:4] pulse_us
   output logic        rsp_tlast    // last
);

`include "sbus_frame_decoder_assert.svh"

   parse_state_type state_ff, state_in;
   logic [4:0]  byte_count_ff, byte_count_in;
   logic [4:0]  rd_addr_ff, rd_addr_in;
   logic [9:0]  acc_ff, acc_in;
   logic [3:0]  nbits_ff, nbits_in;
   logic [3:0]  chan_ff, chan_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  channel_ff;
   logic [11:0] pulse_ff;
   logic        last_ff;

   logic [7:0]  frame_mem [DATA_LEN];
   logic [7:0]  rd_data_ff;

   logic        req_fire;
   logic        mem_we;
   logic [4:0]  wr_addr;
   logic        rd_en;
   logic        out_load;
   logic        slot_free;
   logic [17:0] merged;
   logic [4:0]  total_bits;

   assign req_fire  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign wr_addr   = byte_count_ff - DATA_FIRST;
   assign merged    = 18'(acc_ff) | (18'(rd_data_ff) << nbits_ff);
   assign total_bits = {1'b0, nbits_ff} + {1'b0, BYTE_BITS};

   // Frame memory: write while collecting, registered read while decoding
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[wr_addr] <= req_tdata;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr_ff];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_HUNT;
         byte_count_ff <= '0;
         rd_addr_ff    <= '0;
         acc_ff        <= '0;
         nbits_ff      <= '0;
         chan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         rd_addr_ff    <= rd_addr_in;
         acc_ff        <= acc_in;
         nbits_ff      <= nbits_in;
         chan_ff       <= chan_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         channel_ff <= chan_ff;
         pulse_ff   <= map_pulse(merged[10:0]);
         last_ff    <= (chan_ff == LAST_CHAN);
      end
   end

   // Next state: parse incoming bytes, then walk the stored frame
   always_comb begin
      state_in      = state_ff;
      byte_count_in = byte_count_ff;
      rd_addr_in    = rd_addr_ff;
      acc_in        = acc_ff;
      nbits_in      = nbits_ff;
      chan_in       = chan_ff;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      out_load      = 1'b0;
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_HUNT: begin
            req_tready = 1'b1;
            if (req_fire && (req_tdata == START_BYTE)) begin
               state_in      = ST_COLLECT;
               byte_count_in = DATA_FIRST;
            end
         end
         ST_COLLECT: begin
            req_tready = 1'b1;
            if (req_fire) begin
               mem_we        = (byte_count_ff >= DATA_FIRST) && (byte_count_ff <= DATA_LAST);
               byte_count_in = byte_count_ff + 5'd1;
               if (byte_count_ff == FRAME_END) begin
                  byte_count_in = '0;
                  if (end_ok(req_tdata)) begin
                     state_in   = ST_READ;
                     rd_addr_in = '0;
                     acc_in     = '0;
                     nbits_in   = '0;
                     chan_in    = '0;
                  end else begin
                     state_in = ST_SKIP;
                  end
               end
            end
         end
         ST_SKIP: begin
            req_tready = 1'b1;
            if (req_fire && end_ok(req_tdata)) begin
               state_in      = ST_HUNT;
               byte_count_in = '0;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_USE;
         end
         ST_USE: begin
            if (total_bits >= {1'b0, CHAN_BITS}) begin
               // A full channel is ready: hold until the output slot frees
               if (slot_free) begin
                  out_load = 1'b1;
                  acc_in   = 10'(merged >> CHAN_BITS);
                  nbits_in = 4'(total_bits - {1'b0, CHAN_BITS});
                  chan_in  = chan_ff + 4'd1;
                  if (rd_addr_ff == LAST_ADDR) begin
                     state_in = ST_HUNT;
                  end else begin
                     rd_addr_in = rd_addr_ff + 5'd1;
                     state_in   = ST_READ;
                  end
               end
            end else begin
               acc_in     = 10'(merged);
               nbits_in   = 4'(total_bits);
               rd_addr_in = rd_addr_ff + 5'd1;
               state_in   = ST_READ;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   // Output register: load on a decoded channel, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {pulse_ff, channel_ff};
   assign rsp_tlast  = last_ff;

   `SBUSFD_ASSERT(a_last_on_last_byte, clock, reset, (out_load && (chan_ff == LAST_CHAN)) |-> (rd_addr_ff == LAST_ADDR), "last channel decoded before the last stored byte")
   `SBUSFD_ASSERT(a_no_overwrite, clock, reset, out_load |-> slot_free, "output register overwritten before transfer")
   `SBUSFD_ASSERT(a_decode_start, clock, reset, (state_ff == ST_READ && $past(state_ff) == ST_COLLECT) |-> (chan_ff == 4'd0 && nbits_ff == 4'd0), "decode started with stale accumulator")
   `SBUSFD_ASSERT(a_nbits_range, clock, reset, nbits_ff <= 4'd10, "bit accumulator holds too many leftover bits")

endmodule

// File: test/sbus_frame_checker.sv
`timescale 1ns / 1ps

// Watch both streams, rebuild each frame from the accepted bytes and check
// the sixteen channel transfers that every good frame must produce.
module sbus_frame_checker
   import sbusfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [3:0] channel, [15:4] pulse_us
   input  logic        rsp_tlast,   // last
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [3:0]  chan;
      logic [11:0] pulse_us;
      logic        last;
   } channel_result_type;

   channel_result_type pulse_queue [$];
   parse_state_type    mode = ST_HUNT;
   logic [4:0]         byte_pos = '0;
   logic [7:0]         frame_bytes [DATA_LEN];
   int                 mismatches = 0;
   channel_result_type want;
   channel_result_type got;
   logic               field_bad;

   // A frame closes on 0x00 or on the end-marker bit pattern
   function automatic logic frame_closes(input logic [7:0] b);
      return (b == 8'h00) || ((b & END_MASK) == END_MATCH);
   endfunction

   // Scale the excess over the offset by 1/1.6 with rounding and add the base; clamp low values to the base
   function automatic logic [11:0] pulse_width(input logic [10:0] v);
      int excess;
      excess = int'(v) - int'(VAL_OFFSET);
      if (excess < 0) begin
         return PULSE_BASE;
      end
      return 12'((excess * 5 + 4) / 8 + int'(PULSE_BASE));
   endfunction

   // Unpack the stored data bytes into sixteen expected channel transfers
   task automatic queue_frame();
      logic [DATA_LEN*8-1:0] bits;
      channel_result_type    item;
      for (int i = 0; i < DATA_LEN; i++) begin
         bits[i*8 +: 8] = frame_bytes[i];
      end
      for (int c = 0; c <= int'(LAST_CHAN); c++) begin
         item.chan     = 4'(c);
         item.pulse_us = pulse_width(bits[c*11 +: 11]);
         item.last     = (4'(c) == LAST_CHAN);
         pulse_queue.push_back(item);
      end
   endtask

   // Advance the frame parser by one accepted byte
   task automatic take_byte(input logic [7:0] b);
      case (mode)
         ST_COLLECT: begin
            if (byte_pos >= DATA_FIRST && byte_pos <= DATA_LAST) begin
               frame_bytes[int'(byte_pos) - 1] = b;
            end
            if (byte_pos != FRAME_END) begin
               byte_pos = byte_pos + 5'd1;
            end else begin
               byte_pos = '0;
               if (frame_closes(b)) begin
                  mode = ST_HUNT;
                  queue_frame();
               end else begin
                  mode = ST_SKIP;
               end
            end
         end
         ST_SKIP: begin
            if (frame_closes(b)) begin
               mode     = ST_HUNT;
               byte_pos = '0;
            end
         end
         default: begin
            if (b == START_BYTE) begin
               mode     = ST_COLLECT;
               byte_pos = DATA_FIRST;
            end else begin
               mode     = ST_HUNT;
               byte_pos = '0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode     = ST_HUNT;
         byte_pos = '0;
         pulse_queue.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            take_byte(req_tdata);
         end
         // Compare each result transfer against the oldest expected channel
         if (rsp_tvalid && rsp_tready) begin
            got.chan     = rsp_tdata[3:0];
            got.pulse_us = rsp_tdata[15:4];
            got.last     = rsp_tlast;
            if (pulse_queue.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transfer chan %0d pulse %0d last %0b",
                        $time, got.chan, got.pulse_us, got.last);
            end else begin
               want      = pulse_queue.pop_front();
               field_bad = (got.chan !== want.chan) || (got.pulse_us !== want.pulse_us) ||
                           (got.last !== want.last);
               if (field_bad) begin
                  mismatches++;
                  $display("%0t: expected chan %0d pulse %0d last %0b,", $time,
                           want.chan, want.pulse_us, want.last,
                           " got chan %0d pulse %0d last %0b",
                           got.chan, got.pulse_us, got.last);
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= pulse_queue.size();
   end

endmodule

// File: test/sbus_frame_decoder_tb.sv
`timescale 1ns / 1ps

module sbus_frame_decoder_tb
   import sbusfd_pkg::*;
;

   localparam int BYTE_TARGET = 140;
   localparam int IDLE_LIMIT  = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;

   logic [10:0] chan_vals [16];
   bit          burst = 1'b0;
   int          bytes_sent = 0;
   int          idle_cycles = 0;
   int          ready_hold = 0;
   int          ready_pick;
   int          random_base;
   int          kind;

   always #4 clock = ~clock;

   sbus_frame_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sbus_frame_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Stall the result stream: long ready stretches, short stalls, a few long ones
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 50) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 20);
         end else if (ready_pick < 90) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(10, 60);
         end
      end
   end

   // Abort when no transfer happens on either stream for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Channel values weighted toward the extremes and the saturation knee
   function automatic logic [10:0] rand_chan();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return $urandom_range(0, 1) ? 11'h7ff : 11'h000;
      end
      if (r < 3) begin
         return 11'($urandom_range(190, 210));
      end
      return 11'($urandom_range(0, 2047));
   endfunction

   function automatic logic [7:0] good_end();
      logic [7:0] r;
      r = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
         return 8'h00;
      end
      return (r & ~END_MASK) | END_MATCH;
   endfunction

   function automatic logic [7:0] bad_end();
      logic [7:0] r;
      r = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) begin
         return r | 8'h80;
      end
      return (r & 8'hfb) | 8'h01;
   endfunction

   // Offer one byte after an optional gap and hold it until accepted
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Pack chan_vals into a full 25-byte frame and send it
   task automatic send_frame(input logic [7:0] flags, input logic [7:0] end_b);
      logic [DATA_LEN*8-1:0] payload;
      for (int c = 0; c < 16; c++) begin
         payload[c*11 +: 11] = chan_vals[c];
      end
      send_byte(START_BYTE);
      for (int i = 0; i < DATA_LEN; i++) begin
         send_byte(payload[i*8 +: 8]);
      end
      send_byte(flags);
      send_byte(end_b);
   endtask

   task automatic randomize_chans();
      for (int c = 0; c < 16; c++) begin
         chan_vals[c] = rand_chan();
      end
   endtask

   // Hold off the sender until every expected channel has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Noise while hunting, none of it a start byte
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'hf0);

      // Saturation knee and bit patterns, zero end byte
      for (int c = 0; c < 16; c++) begin
         chan_vals[c] = 11'h7ff;
      end
      chan_vals[0] = 11'd0;
      chan_vals[1] = 11'd199;
      chan_vals[2] = 11'd200;
      chan_vals[3] = 11'd201;
      chan_vals[4] = 11'd202;
      chan_vals[5] = 11'h555;
      chan_vals[6] = 11'h2aa;
      send_frame(8'h00, 8'h00);

      // All channels at full scale, end byte matching the marker pattern
      for (int c = 0; c < 16; c++) begin
         chan_vals[c] = 11'h7ff;
      end
      send_frame(8'hff, 8'h3f);

      // Bad end byte, drop bytes until a marker (0x0f counts as one), resync
      randomize_chans();
      send_frame(8'h5a, END_MASK);
      send_byte(8'h80);
      send_byte(START_BYTE);
      randomize_chans();
      send_frame(8'ha5, END_MATCH);
      drain();

      // Mostly well-formed frames, some broken ones and some line noise
      random_base = bytes_sent;
      while (bytes_sent - random_base < BYTE_TARGET) begin
         burst = ($urandom_range(0, 3) == 0);
         kind  = $urandom_range(0, 99);
         if (kind < 70) begin
            randomize_chans();
            send_frame(8'($urandom_range(0, 255)), good_end());
         end else if (kind < 85) begin
            randomize_chans();
            send_frame(8'($urandom_range(0, 255)), bad_end());
            repeat ($urandom_range(0, 3)) send_byte(bad_end());
            send_byte(good_end());
         end else begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 7) == 0) begin
            drain();
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
